>>> design/rtlpm_pkg.sv
// ----------------------------------------------------------------------------
// rtlpm_pkg
// Shared types, codes and defaults of the IPv4 longest prefix match table.
// ----------------------------------------------------------------------------
package rtlpm_pkg;

   localparam int TABLE_SLOTS_DEF       = 4;
   localparam int ENTRIES_PER_TABLE_DEF = 64;

   typedef enum logic [2:0] {
      OP_ADD       = 3'd0,
      OP_DELETE    = 3'd1,
      OP_LOOKUP    = 3'd2,
      OP_FLUSH_TBL = 3'd3,
      OP_FLUSH_ALL = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_TABLE_FULL = 3'd1,
      ST_NO_SLOT    = 3'd2,
      ST_NOT_FOUND  = 3'd3,
      ST_NO_ROUTE   = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_ADD_SCAN,
      S_SCAN,
      S_DRAIN,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [7:0]  route_table;
      logic [31:0] dest_addr;
      logic [31:0] prefix_mask;
      logic [31:0] gateway;
      logic [7:0]  iface_index;
      logic [15:0] route_metric;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] hop_addr;
      logic [7:0]  out_iface;
      logic [5:0]  matched_prefix;
   } rsp_payload_type;

   typedef struct packed {
      logic [31:0] dest;
      logic [31:0] mask;
      logic [31:0] gateway;
      logic [7:0]  iface;
      logic [15:0] metric;
      logic [31:0] order;
   } route_entry_type;

   typedef struct packed {
      logic        found;
      logic        same_slot;
      logic [5:0]  len;
      logic [15:0] metric;
      logic [31:0] order;
   } cmp_best_type;

   typedef struct packed {
      logic       hit;
      logic       better;
      logic [5:0] len;
   } cmp_out_type;

endpackage

>>> design/ipv4_route_table_lpm.sv
// ----------------------------------------------------------------------------
// ipv4_route_table_lpm
// IPv4 forwarding table with numbered route tables and longest prefix match.
// ----------------------------------------------------------------------------
// Requests enter on req_valid/req_ready with a req_payload of type
// req_payload_type (add, delete, lookup, flush table, flush all). Every
// request gives exactly one response on rsp_valid/rsp_ready as rsp_payload.
// The block takes one request at a time; req_ready is high only when idle.
// Lookup scans all TABLE_SLOTS*ENTRIES_PER_TABLE entries and delete the
// ENTRIES_PER_TABLE entries of its table, one entry per cycle read from the
// entry RAM and fed to the shared compare unit. Add steps past the occupied
// entries of its table up to the first free one; flushes and rejected
// requests go straight to the response.
// The response sits in an output register; a new request is accepted while
// it waits, and a finished request holds until that register frees up.
// Reset clears all table slots, route counts, entry valid bits and the
// insertion counter; entry RAM contents need no clearing.
// ----------------------------------------------------------------------------
module ipv4_route_table_lpm #(
   parameter int TABLE_SLOTS       = rtlpm_pkg::TABLE_SLOTS_DEF,
   parameter int ENTRIES_PER_TABLE = rtlpm_pkg::ENTRIES_PER_TABLE_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  rtlpm_pkg::req_payload_type req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rtlpm_pkg::rsp_payload_type rsp_payload
);
   import rtlpm_pkg::*;

   localparam int ENTRY_TOTAL = TABLE_SLOTS * ENTRIES_PER_TABLE;
   localparam int IDX_W  = (ENTRY_TOTAL > 1) ? $clog2(ENTRY_TOTAL) : 1;
   localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int K_W    = (ENTRIES_PER_TABLE > 1) ? $clog2(ENTRIES_PER_TABLE) : 1;
   localparam int CNT_W  = $clog2(ENTRIES_PER_TABLE + 1);
   localparam int REM_W  = $clog2(ENTRY_TOTAL + 1);
   localparam int ENT_W  = $bits(route_entry_type);

   state_type        state_ff, state_in;
   req_payload_type  req_ff, req_in;
   logic [7:0]       slot_num_ff [TABLE_SLOTS];
   logic [7:0]       slot_num_in [TABLE_SLOTS];
   logic [CNT_W-1:0] slot_cnt_ff [TABLE_SLOTS];
   logic [CNT_W-1:0] slot_cnt_in [TABLE_SLOTS];
   logic             valid_ff [ENTRY_TOTAL];
   logic [31:0]      seq_ff, seq_in;
   logic [IDX_W-1:0] addr_ff, addr_in;
   logic [K_W-1:0]   k_ff, k_in;
   logic [SLOT_W-1:0] cur_slot_ff, cur_slot_in;
   logic [SLOT_W-1:0] sel_slot_ff, sel_slot_in;
   logic [REM_W-1:0] remain_ff, remain_in;
   logic             p_act_ff, p_act_in;
   logic             p_vld_ff, p_vld_in;
   logic [SLOT_W-1:0] p_slot_ff, p_slot_in;
   logic [IDX_W-1:0] p_idx_ff, p_idx_in;
   logic             best_found_ff, best_found_in;
   logic [5:0]       best_len_ff, best_len_in;
   logic [15:0]      best_metric_ff, best_metric_in;
   logic [31:0]      best_order_ff, best_order_in;
   logic [SLOT_W-1:0] best_slot_ff, best_slot_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;
   logic [31:0]      best_gw_ff, best_gw_in;
   logic [7:0]       best_iface_ff, best_iface_in;
   status_type       status_ff, status_in;
   rsp_payload_type  rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic             hit_found, free_found;
   logic [SLOT_W-1:0] hit_slot, free_slot;
   logic             slot_clr [TABLE_SLOTS];
   logic             set_en, clr_en;
   logic [IDX_W-1:0] set_idx, clr_idx;
   logic             ram_we;
   route_entry_type  ram_wdata;
   logic [ENT_W-1:0] ram_rdata;
   route_entry_type  rd_entry;
   cmp_best_type     cmp_best;
   cmp_out_type      cmp_res;
   logic             is_lookup;

   rtlpm_ram #(
      .WIDTH (ENT_W),
      .DEPTH (ENTRY_TOTAL),
      .AW    (IDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (addr_ff),
      .wr_data (ram_wdata),
      .rd_en   (state_ff == S_SCAN),
      .rd_addr (addr_ff),
      .rd_data (ram_rdata)
   );

   assign rd_entry  = route_entry_type'(ram_rdata);
   assign is_lookup = (req_ff.req_type == OP_LOOKUP);

   always_comb begin
      cmp_best.found     = best_found_ff;
      cmp_best.same_slot = (p_slot_ff == best_slot_ff);
      cmp_best.len       = best_len_ff;
      cmp_best.metric    = best_metric_ff;
      cmp_best.order     = best_order_ff;
   end

   rtlpm_cmp u_cmp (
      .entry     (rd_entry),
      .is_lookup (is_lookup),
      .key_addr  (req_ff.dest_addr),
      .key_mask  (req_ff.prefix_mask),
      .best      (cmp_best),
      .result    (cmp_res)
   );

   always_comb begin
      hit_found  = 1'b0;
      hit_slot   = '0;
      free_found = 1'b0;
      free_slot  = '0;
      for (int i = 0; i < TABLE_SLOTS; i++) begin
         if (!hit_found && req_ff.route_table != 8'd0 &&
             slot_num_ff[i] == req_ff.route_table) begin
            hit_found = 1'b1;
            hit_slot  = SLOT_W'(i);
         end
         if (!free_found && slot_num_ff[i] == 8'd0) begin
            free_found = 1'b1;
            free_slot  = SLOT_W'(i);
         end
      end
   end

   always_comb begin
      state_in       = state_ff;
      req_in         = req_ff;
      slot_num_in    = slot_num_ff;
      slot_cnt_in    = slot_cnt_ff;
      seq_in         = seq_ff;
      addr_in        = addr_ff;
      k_in           = k_ff;
      cur_slot_in    = cur_slot_ff;
      sel_slot_in    = sel_slot_ff;
      remain_in      = remain_ff;
      p_act_in       = 1'b0;
      p_vld_in       = 1'b0;
      p_slot_in      = cur_slot_ff;
      p_idx_in       = addr_ff;
      best_found_in  = best_found_ff;
      best_len_in    = best_len_ff;
      best_metric_in = best_metric_ff;
      best_order_in  = best_order_ff;
      best_slot_in   = best_slot_ff;
      best_idx_in    = best_idx_ff;
      best_gw_in     = best_gw_ff;
      best_iface_in  = best_iface_ff;
      status_in      = status_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      for (int i = 0; i < TABLE_SLOTS; i++) begin
         slot_clr[i] = 1'b0;
      end
      set_en    = 1'b0;
      set_idx   = addr_ff;
      clr_en    = 1'b0;
      clr_idx   = best_idx_ff;
      ram_we    = 1'b0;
      ram_wdata.dest    = req_ff.dest_addr & req_ff.prefix_mask;
      ram_wdata.mask    = req_ff.prefix_mask;
      ram_wdata.gateway = req_ff.gateway;
      ram_wdata.iface   = req_ff.iface_index;
      ram_wdata.metric  = req_ff.route_metric;
      ram_wdata.order   = seq_ff;
      req_ready = (state_ff == S_IDLE);

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_payload;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            best_found_in = 1'b0;
            status_in     = ST_OK;
            state_in      = S_FINISH;
            case (req_ff.req_type)
               OP_ADD: begin
                  if (req_ff.route_table == 8'd0) begin
                     status_in = ST_NO_SLOT;
                  end else if (hit_found) begin
                     if (32'(slot_cnt_ff[hit_slot]) >= ENTRIES_PER_TABLE) begin
                        status_in = ST_TABLE_FULL;
                     end else begin
                        sel_slot_in = hit_slot;
                        addr_in     = IDX_W'(32'(hit_slot) * ENTRIES_PER_TABLE);
                        state_in    = S_ADD_SCAN;
                     end
                  end else if (free_found) begin
                     slot_num_in[free_slot] = req_ff.route_table;
                     slot_cnt_in[free_slot] = '0;
                     slot_clr[free_slot]    = 1'b1;
                     sel_slot_in = free_slot;
                     addr_in     = IDX_W'(32'(free_slot) * ENTRIES_PER_TABLE);
                     state_in    = S_ADD_SCAN;
                  end else begin
                     status_in = ST_NO_SLOT;
                  end
               end
               OP_DELETE: begin
                  if (!hit_found) begin
                     status_in = ST_NOT_FOUND;
                  end else begin
                     sel_slot_in = hit_slot;
                     cur_slot_in = hit_slot;
                     addr_in     = IDX_W'(32'(hit_slot) * ENTRIES_PER_TABLE);
                     k_in        = '0;
                     remain_in   = REM_W'(ENTRIES_PER_TABLE);
                     state_in    = S_SCAN;
                  end
               end
               OP_LOOKUP: begin
                  cur_slot_in = '0;
                  addr_in     = '0;
                  k_in        = '0;
                  remain_in   = REM_W'(ENTRY_TOTAL);
                  state_in    = S_SCAN;
               end
               OP_FLUSH_TBL: begin
                  if (!hit_found) begin
                     status_in = ST_NOT_FOUND;
                  end else begin
                     slot_clr[hit_slot]    = 1'b1;
                     slot_cnt_in[hit_slot] = '0;
                  end
               end
               OP_FLUSH_ALL: begin
                  for (int i = 0; i < TABLE_SLOTS; i++) begin
                     slot_clr[i]    = 1'b1;
                     slot_cnt_in[i] = '0;
                  end
               end
               default: begin
               end
            endcase
         end
         S_ADD_SCAN: begin
            if (!valid_ff[addr_ff]) begin
               ram_we   = 1'b1;
               set_en   = 1'b1;
               slot_cnt_in[sel_slot_ff] = slot_cnt_ff[sel_slot_ff] + CNT_W'(1);
               seq_in   = seq_ff + 32'd1;
               state_in = S_FINISH;
            end else begin
               addr_in = addr_ff + IDX_W'(1);
            end
         end
         S_SCAN: begin
            p_act_in  = 1'b1;
            p_vld_in  = valid_ff[addr_ff] && (slot_num_ff[cur_slot_ff] != 8'd0);
            addr_in   = addr_ff + IDX_W'(1);
            remain_in = remain_ff - REM_W'(1);
            if (32'(k_ff) == ENTRIES_PER_TABLE - 1) begin
               k_in        = '0;
               cur_slot_in = cur_slot_ff + SLOT_W'(1);
            end else begin
               k_in = k_ff + K_W'(1);
            end
            if (remain_ff == REM_W'(1)) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.status         = status_ff;
               rsp_in.hop_addr       = '0;
               rsp_in.out_iface      = '0;
               rsp_in.matched_prefix = '0;
               if (req_ff.req_type == OP_LOOKUP) begin
                  if (best_found_ff) begin
                     rsp_in.status         = ST_OK;
                     rsp_in.hop_addr       = (best_gw_ff != 32'd0) ? best_gw_ff
                                                                  : req_ff.dest_addr;
                     rsp_in.out_iface      = best_iface_ff;
                     rsp_in.matched_prefix = best_len_ff;
                  end else begin
                     rsp_in.status = ST_NO_ROUTE;
                  end
               end else if (req_ff.req_type == OP_DELETE && status_ff == ST_OK) begin
                  if (best_found_ff) begin
                     clr_en = 1'b1;
                     if (slot_cnt_ff[sel_slot_ff] != '0) begin
                        slot_cnt_in[sel_slot_ff] = slot_cnt_ff[sel_slot_ff] - CNT_W'(1);
                     end
                  end else begin
                     rsp_in.status = ST_NOT_FOUND;
                  end
               end
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (p_act_ff && p_vld_ff && cmp_res.hit && cmp_res.better) begin
         best_found_in  = 1'b1;
         best_len_in    = cmp_res.len;
         best_metric_in = rd_entry.metric;
         best_order_in  = rd_entry.order;
         best_slot_in   = p_slot_ff;
         best_idx_in    = p_idx_ff;
         best_gw_in     = rd_entry.gateway;
         best_iface_in  = rd_entry.iface;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         seq_ff        <= '0;
         p_act_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         best_found_ff <= 1'b0;
         for (int i = 0; i < TABLE_SLOTS; i++) begin
            slot_num_ff[i] <= '0;
            slot_cnt_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         seq_ff        <= seq_in;
         p_act_ff      <= p_act_in;
         rsp_valid_ff  <= rsp_valid_in;
         best_found_ff <= best_found_in;
         slot_num_ff   <= slot_num_in;
         slot_cnt_ff   <= slot_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff         <= req_in;
      addr_ff        <= addr_in;
      k_ff           <= k_in;
      cur_slot_ff    <= cur_slot_in;
      sel_slot_ff    <= sel_slot_in;
      remain_ff      <= remain_in;
      p_vld_ff       <= p_vld_in;
      p_slot_ff      <= p_slot_in;
      p_idx_ff       <= p_idx_in;
      best_len_ff    <= best_len_in;
      best_metric_ff <= best_metric_in;
      best_order_ff  <= best_order_in;
      best_slot_ff   <= best_slot_in;
      best_idx_ff    <= best_idx_in;
      best_gw_ff     <= best_gw_in;
      best_iface_ff  <= best_iface_in;
      status_ff      <= status_in;
      rsp_ff         <= rsp_in;
   end

   for (genvar g = 0; g < ENTRY_TOTAL; g++) begin : g_valid
      localparam int SLOT_OF = g / ENTRIES_PER_TABLE;
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else if (slot_clr[SLOT_OF]) begin
            valid_ff[g] <= 1'b0;
         end else if (set_en && set_idx == IDX_W'(g)) begin
            valid_ff[g] <= 1'b1;
         end else if (clr_en && clr_idx == IDX_W'(g)) begin
            valid_ff[g] <= 1'b0;
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

>>> design/rtlpm_ram.sv
// ----------------------------------------------------------------------------
// rtlpm_ram
// Simple dual port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module rtlpm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/rtlpm_cmp.sv
// ----------------------------------------------------------------------------
// rtlpm_cmp
// Route match and preference compare for one stored entry.
// ----------------------------------------------------------------------------
module rtlpm_cmp (
   input  rtlpm_pkg::route_entry_type entry,
   input  logic                       is_lookup,
   input  logic [31:0]                key_addr,
   input  logic [31:0]                key_mask,
   input  rtlpm_pkg::cmp_best_type    best,
   output rtlpm_pkg::cmp_out_type     result
);
   import rtlpm_pkg::*;

   logic [5:0] len;
   logic       hit;
   logic       pref;

   always_comb begin
      len = 6'($countones(entry.mask));
      if (is_lookup) begin
         hit = (key_addr & entry.mask) == entry.dest;
      end else begin
         hit = (entry.dest == (key_addr & key_mask)) && (entry.mask == key_mask);
      end
      pref = (entry.metric < best.metric) ||
             ((entry.metric == best.metric) && (entry.order < best.order));
      result.hit = hit;
      result.len = len;
      if (is_lookup) begin
         result.better = !best.found || (len > best.len) ||
                         ((len == best.len) && best.same_slot && pref);
      end else begin
         result.better = !best.found || pref;
      end
   end

endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the IPv4 longest prefix match route table. Requests
// come from a queue filled by the stimulus process, a clocked driver offers
// them, and a clocked monitor checks each response against a behavioral
// route table model kept in this bench.
// ----------------------------------------------------------------------------
module tb_top;
   import rtlpm_pkg::*;

   localparam int SLOTS   = TABLE_SLOTS_DEF;
   localparam int PER_TBL = ENTRIES_PER_TABLE_DEF;
   localparam int ENTRIES = SLOTS * PER_TBL;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;

   ipv4_route_table_lpm u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload)
   );

   always #10 clock = ~clock;

   // route table model
   logic [7:0]  tbl_num[SLOTS];
   int          tbl_cnt[SLOTS];
   logic        rt_valid[ENTRIES];
   logic [31:0] rt_dest[ENTRIES];
   logic [31:0] rt_mask[ENTRIES];
   logic [31:0] rt_gw[ENTRIES];
   logic [7:0]  rt_ifc[ENTRIES];
   logic [15:0] rt_metric[ENTRIES];
   logic [31:0] rt_order[ENTRIES];
   logic [31:0] next_order;

   req_payload_type pending_reqs[$];
   rsp_payload_type expected_rsps[$];
   int send_idle_pct = 25;
   int recv_idle_pct = 45;
   int hold_cycles = 0;
   int mismatches = 0;
   int checked = 0;
   int n_lookup_hits = 0;
   bit req_fire = 1'b0;

   function automatic int find_table(logic [7:0] id);
      if (id == 0) return -1;
      for (int s = 0; s < SLOTS; s++) if (tbl_num[s] == id) return s;
      return -1;
   endfunction

   function automatic void clear_table(int s);
      for (int k = 0; k < PER_TBL; k++) rt_valid[s*PER_TBL+k] = 1'b0;
      tbl_cnt[s] = 0;
   endfunction

   function automatic rsp_payload_type route_predict(req_payload_type r);
      rsp_payload_type o;
      int s, pick, best, bslot, blen, len, e;
      logic [31:0] key;
      o = '0;
      o.status = ST_OK;
      case (r.req_type)
         OP_ADD: begin
            if (r.route_table == 0) begin
               o.status = ST_NO_SLOT;
               return o;
            end
            s = find_table(r.route_table);
            if (s < 0) begin
               for (int k = 0; k < SLOTS; k++)
                  if (s < 0 && tbl_num[k] == 0) s = k;
               if (s < 0) begin
                  o.status = ST_NO_SLOT;
                  return o;
               end
               tbl_num[s] = r.route_table;
               clear_table(s);
            end
            if (tbl_cnt[s] >= PER_TBL) begin
               o.status = ST_TABLE_FULL;
               return o;
            end
            for (int k = 0; k < PER_TBL; k++) begin
               e = s*PER_TBL + k;
               if (!rt_valid[e]) begin
                  rt_valid[e] = 1'b1;
                  rt_dest[e] = r.dest_addr & r.prefix_mask;
                  rt_mask[e] = r.prefix_mask;
                  rt_gw[e] = r.gateway;
                  rt_ifc[e] = r.iface_index;
                  rt_metric[e] = r.route_metric;
                  rt_order[e] = next_order;
                  next_order = next_order + 1;
                  tbl_cnt[s]++;
                  return o;
               end
            end
            o.status = ST_TABLE_FULL;
         end
         OP_DELETE: begin
            s = find_table(r.route_table);
            pick = -1;
            key = r.dest_addr & r.prefix_mask;
            if (s >= 0)
               for (int k = 0; k < PER_TBL; k++) begin
                  e = s*PER_TBL + k;
                  if (rt_valid[e] && rt_dest[e] == key && rt_mask[e] == r.prefix_mask)
                     if (pick < 0 || rt_metric[e] < rt_metric[pick] ||
                         (rt_metric[e] == rt_metric[pick] && rt_order[e] < rt_order[pick]))
                        pick = e;
               end
            if (pick < 0) o.status = ST_NOT_FOUND;
            else begin
               rt_valid[pick] = 1'b0;
               if (tbl_cnt[s] > 0) tbl_cnt[s]--;
            end
         end
         OP_LOOKUP: begin
            best = -1; bslot = -1; blen = 0;
            for (int t = 0; t < SLOTS; t++) begin
               if (tbl_num[t] == 0) continue;
               for (int k = 0; k < PER_TBL; k++) begin
                  e = t*PER_TBL + k;
                  if (!rt_valid[e] || (r.dest_addr & rt_mask[e]) != rt_dest[e]) continue;
                  len = $countones(rt_mask[e]);
                  if (best < 0 || len > blen ||
                      (len == blen && t == bslot &&
                       (rt_metric[e] < rt_metric[best] ||
                        (rt_metric[e] == rt_metric[best] && rt_order[e] < rt_order[best])))) begin
                     best = e; bslot = t; blen = len;
                  end
               end
            end
            if (best < 0) o.status = ST_NO_ROUTE;
            else begin
               o.hop_addr = rt_gw[best] != 0 ? rt_gw[best] : r.dest_addr;
               o.out_iface = rt_ifc[best];
               o.matched_prefix = blen[5:0];
            end
         end
         OP_FLUSH_TBL: begin
            s = find_table(r.route_table);
            if (s < 0) o.status = ST_NOT_FOUND;
            else clear_table(s);
         end
         OP_FLUSH_ALL: for (int t = 0; t < SLOTS; t++) clear_table(t);
         default: ;
      endcase
      return o;
   endfunction

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (req_fire && pending_reqs.size() > 0)
            void'(pending_reqs.pop_front());
         if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_payload <= pending_reqs[0];
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      req_fire = !reset && req_valid && req_ready;
      if (req_fire)
         expected_rsps.push_back(route_predict(req_payload));
   end

   // receiver ready
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_payload_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %p", rsp_payload);
         end else begin
            exp_r = expected_rsps.pop_front();
            checked++;
            if (exp_r.status == ST_OK && exp_r.matched_prefix != 0) n_lookup_hits++;
            if (rsp_payload.status !== exp_r.status ||
                rsp_payload.hop_addr !== exp_r.hop_addr ||
                rsp_payload.out_iface !== exp_r.out_iface ||
                rsp_payload.matched_prefix !== exp_r.matched_prefix) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p actual %p", exp_r, rsp_payload);
            end
         end
      end
   end

   function automatic req_payload_type mk_req(logic [2:0] op, logic [7:0] id,
         logic [31:0] d, logic [31:0] m, logic [31:0] g, logic [7:0] i, logic [15:0] mt);
      req_payload_type r;
      r.req_type = op; r.route_table = id; r.dest_addr = d; r.prefix_mask = m;
      r.gateway = g; r.iface_index = i; r.route_metric = mt;
      return r;
   endfunction

   function automatic logic [31:0] rand_mask();
      int len;
      if ($urandom_range(9) == 0) return $urandom;
      len = $urandom_range(32);
      return len == 0 ? 32'h0 : ~32'h0 << (32 - len);
   endfunction

   // pick ids from a small set so tables get reused, with rare extremes
   function automatic logic [7:0] rand_id();
      case ($urandom_range(9))
         0: return 8'd0;
         1: return 8'hFF;
         2: return 8'($urandom);
         default: return 8'($urandom_range(1, 5));
      endcase
   endfunction

   function automatic req_payload_type rand_req(int mode);
      logic [2:0] op;
      logic [31:0] base;
      int p;
      p = $urandom_range(99);
      if (mode == 1) op = p < 60 ? OP_ADD : (p < 70 ? OP_DELETE : OP_LOOKUP);
      else if (p < 35) op = OP_ADD;
      else if (p < 50) op = OP_DELETE;
      else if (p < 92) op = OP_LOOKUP;
      else if (p < 96) op = OP_FLUSH_TBL;
      else if (p < 98) op = OP_FLUSH_ALL;
      else op = 3'($urandom_range(5, 7));
      base = {8'd10, 8'($urandom_range(3)), 16'($urandom)};
      return mk_req(op, rand_id(), $urandom_range(3) == 0 ? $urandom : base,
                    $urandom_range(3) == 0 ? $urandom : rand_mask(),
                    $urandom_range(2) == 0 ? 32'h0 : $urandom, 8'($urandom),
                    $urandom_range(1) ? 16'($urandom_range(3)) : 16'($urandom));
   endfunction

   task automatic wait_drained();
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      for (int s = 0; s < SLOTS; s++) begin
         tbl_num[s] = '0;
         tbl_cnt[s] = 0;
      end
      for (int e = 0; e < ENTRIES; e++) rt_valid[e] = 1'b0;
      next_order = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      pending_reqs.push_back(mk_req(OP_LOOKUP, 0, 32'h0A000001, 0, 0, 0, 0));
      pending_reqs.push_back(mk_req(OP_ADD, 0, 32'h0A000000, 32'hFF000000, 0, 1, 0));
      pending_reqs.push_back(mk_req(OP_DELETE, 0, 0, 0, 0, 0, 0));
      pending_reqs.push_back(mk_req(OP_FLUSH_TBL, 0, 0, 0, 0, 0, 0));
      pending_reqs.push_back(mk_req(OP_DELETE, 9, 0, 0, 0, 0, 0));
      pending_reqs.push_back(mk_req(OP_FLUSH_TBL, 9, 0, 0, 0, 0, 0));
      pending_reqs.push_back(mk_req(OP_ADD, 1, 32'hFFFFFFFF, 32'h0, 32'hFFFFFFFF, 8'hFF,
                                    16'hFFFF));
      pending_reqs.push_back(mk_req(OP_ADD, 1, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 8'h00, 0));
      pending_reqs.push_back(mk_req(OP_ADD, 2, 32'h0A0B0C0D, 32'hFFFF0000, 0, 3, 5));
      pending_reqs.push_back(mk_req(OP_ADD, 2, 32'h0A0B0000, 32'hFFFF0000, 32'h1, 4, 5));
      pending_reqs.push_back(mk_req(OP_ADD, 2, 32'h0A0B0000, 32'hFFFF0000, 32'h2, 5, 2));
      pending_reqs.push_back(mk_req(OP_ADD, 3, 32'h0A0B0000, 32'hFFFF0000, 32'h9, 6, 0));
      pending_reqs.push_back(mk_req(OP_ADD, 3, 32'h0A0F0000, 32'hF0F00000, 0, 7, 1));
      pending_reqs.push_back(mk_req(OP_ADD, 255, 32'h1, 32'h1, 0, 8, 0));
      pending_reqs.push_back(mk_req(OP_ADD, 200, 32'h1, 32'h1, 0, 8, 0));
      pending_reqs.push_back(mk_req(OP_LOOKUP, 0, 32'h0A0B1234, 0, 0, 0, 0));
      pending_reqs.push_back(mk_req(OP_LOOKUP, 0, 32'hFFFFFFFF, 0, 0, 0, 0));
      pending_reqs.push_back(mk_req(OP_LOOKUP, 0, 32'h0A0F0000, 0, 0, 0, 0));
      pending_reqs.push_back(mk_req(OP_DELETE, 2, 32'h0A0BFFFF, 32'hFFFF0000, 0, 0, 0));
      pending_reqs.push_back(mk_req(OP_DELETE, 2, 32'h0A0B0000, 32'hFFFFFF00, 0, 0, 0));
      pending_reqs.push_back(mk_req(OP_LOOKUP, 0, 32'h0A0B0001, 0, 0, 0, 0));
      pending_reqs.push_back(mk_req(3'd7, 1, 0, 0, 0, 0, 0));
      pending_reqs.push_back(mk_req(OP_FLUSH_TBL, 1, 0, 0, 0, 0, 0));
      pending_reqs.push_back(mk_req(OP_FLUSH_ALL, 0, 0, 0, 0, 0, 0));
      pending_reqs.push_back(mk_req(OP_LOOKUP, 0, 32'h0A0B0001, 0, 0, 0, 0));
      wait_drained();

      // offer table 4 more routes than one table holds; no slot is free for it here
      for (int k = 0; k < PER_TBL + 3; k++)
         pending_reqs.push_back(mk_req(OP_ADD, 4, $urandom, rand_mask(), $urandom,
                                       8'($urandom), 16'($urandom_range(3))));
      for (int k = 0; k < 400; k++) pending_reqs.push_back(rand_req(0));
      hold_cycles = 3000;
      wait_drained();

      send_idle_pct = 45;
      recv_idle_pct = 25;
      for (int k = 0; k < 450; k++) pending_reqs.push_back(rand_req(k % 150 < 40 ? 1 : 0));
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (int k = 0; k < 450; k++) pending_reqs.push_back(rand_req(k % 150 < 40 ? 1 : 0));
      wait_drained();

      repeat (ENTRIES + 20) @(posedge clock);
      $display("Covered %0d responses over add/delete/lookup/flush, %0d lookup hits.",
               checked, n_lookup_hits);
      if (mismatches == 0 && expected_rsps.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #60000000;
      $display("CHECKS FAILED");
      $finish;
   end
endmodule
